// ===== src/plcm_pkg.sv =====
// Shared constants for the piecewise linear colormap: stops, colors and divider constants.
`timescale 1ns / 1ps

package plcm_pkg;

    localparam int NumStops = 10;
    localparam int NumChan  = 3;

    localparam int GrayW  = 8;
    localparam int ChanW  = 8;
    localparam int ScaleW = 17;   // 273 * 255 = 69615
    localparam int OffW   = 14;   // offset inside a segment, at most 8500
    localparam int SegW   = 4;    // segment / stop index
    localparam int NumW   = 22;   // color * segment length, at most 255 * 8500
    localparam int RecipW = 14;
    localparam int ProdW  = NumW + RecipW;
    localparam int RecipShift = 24;

    localparam logic [ScaleW-1:0] ScaleNum = 17'd273;

    // Stop positions on the 0..4095 scale, pre-multiplied by 17.
    localparam logic [ScaleW-1:0] STOP_N [NumStops] = '{
        17'd0,     17'd8500,  17'd17000, 17'd25500, 17'd34000,
        17'd42500, 17'd51000, 17'd59500, 17'd68000, 17'd69615
    };

    // Index of the last segment, which is shorter than the others.
    localparam logic [SegW-1:0] LastSeg = 4'd8;

    // Segment lengths (scaled by 17) and their reciprocals, floor(2^24 / len).
    localparam logic [OffW-1:0]   LenLong    = 14'd8500;
    localparam logic [OffW-1:0]   LenShort   = 14'd1615;
    localparam logic [RecipW-1:0] RecipLong  = 14'd1973;
    localparam logic [RecipW-1:0] RecipShort = 14'd10388;

    // Stop colors, channel order blue, green, red.
    localparam logic [ChanW-1:0] STOP_BGR [NumStops][NumChan] = '{
        '{8'd255, 8'd0,   8'd0},
        '{8'd255, 8'd0,   8'd0},
        '{8'd255, 8'd255, 8'd0},
        '{8'd0,   8'd255, 8'd0},
        '{8'd0,   8'd255, 8'd255},
        '{8'd0,   8'd165, 8'd255},
        '{8'd0,   8'd69,  8'd255},
        '{8'd0,   8'd0,   8'd255},
        '{8'd0,   8'd0,   8'd139},
        '{8'd0,   8'd0,   8'd139}
    };

endpackage

// ===== src/plcm_gray_if.sv =====
// Gray pixel channel: valid/ready handshake with an 8-bit gray payload.
`timescale 1ns / 1ps

interface plcm_gray_if;
    logic                            valid;
    logic                            ready;
    logic [plcm_pkg::GrayW-1:0]      gray;

    modport source (output valid, output gray, input ready);
    modport sink   (input valid, input gray, output ready);
endinterface

// ===== src/plcm_bgr_if.sv =====
// Color pixel channel: valid/ready handshake with blue, green and red payload.
`timescale 1ns / 1ps

interface plcm_bgr_if;
    logic                            valid;
    logic                            ready;
    logic [plcm_pkg::ChanW-1:0]      blue;
    logic [plcm_pkg::ChanW-1:0]      green;
    logic [plcm_pkg::ChanW-1:0]      red;

    modport source (output valid, output blue, output green, output red, input ready);
    modport sink   (input valid, input blue, input green, input red, output ready);
endinterface

// ===== src/piecewise_linear_colormap_unit.sv =====
// Piecewise linear colormap: 8-bit gray pixel in, blue/green/red pixel out.
`timescale 1ns / 1ps

// Maps each gray beat to a heat-map color by linear interpolation between ten
// fixed color stops spread over a 0..4095 scale (gray g sits at g*4095/255).
// Each channel is the exact interpolation, rounded down. The unit takes one
// beat per clock while the color side does not stall. A beat passes through
// four register stages, the first of which loads at the edge that accepts it
// (segment search, interpolation products, reciprocal multiply, quotient
// correction into the output register). Each stage holds its beat only while
// the stage after it is full and stalled, so bubbles are squeezed out and a
// stall on the color side loses and repeats nothing. The unit keeps no state
// between pixels.
module piecewise_linear_colormap_unit (
    input  logic              clk,
    input  logic              rst_n,
    plcm_gray_if.sink         gray_ch,
    plcm_bgr_if.source        color_ch
);

    // Stage enables: a stage may load when it is empty or its beat moves on.
    logic en1, en2, en3, en4;

    // Stage 1: segment index and offset into the segment.
    logic                              v1_reg;
    logic [plcm_pkg::SegW-1:0]         seg_reg,  seg_next;
    logic [plcm_pkg::OffW-1:0]         off_reg,  off_next;
    logic [plcm_pkg::ScaleW-1:0]       scaled;

    // Stage 2: interpolation numerators, one lane per channel.
    logic                              v2_reg;
    logic                              short2_reg;
    logic [plcm_pkg::NumW-1:0]         num2_reg  [plcm_pkg::NumChan];
    logic [plcm_pkg::NumW-1:0]         num2_next [plcm_pkg::NumChan];
    logic [plcm_pkg::OffW-1:0]         seg_len;
    logic [plcm_pkg::OffW-1:0]         off_rest;
    logic [plcm_pkg::SegW-1:0]         seg_hi;

    // Stage 3: numerator times reciprocal of the segment length.
    logic                              v3_reg;
    logic                              short3_reg;
    logic [plcm_pkg::NumW-1:0]         num3_reg  [plcm_pkg::NumChan];
    logic [plcm_pkg::ProdW-1:0]        prod3_reg [plcm_pkg::NumChan];
    logic [plcm_pkg::ProdW-1:0]        prod3_next[plcm_pkg::NumChan];
    logic [plcm_pkg::RecipW-1:0]       recip;

    // Stage 4: corrected quotient, the output register.
    logic                              v4_reg;
    logic [plcm_pkg::ChanW-1:0]        bgr_reg   [plcm_pkg::NumChan];
    logic [plcm_pkg::ChanW-1:0]        bgr_next  [plcm_pkg::NumChan];
    logic [plcm_pkg::OffW-1:0]         div_len;

    assign en4 = !v4_reg || color_ch.ready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign gray_ch.ready = en1;

    // ---------------------------------------------------------------- stage 1
    // Scale gray by 273 (the 17 of 4095/255 is folded into the stop table),
    // then pick the segment whose lower stop is the last one not above it.
    // Gray 255 lands exactly on the top stop: it falls in the last segment at
    // its full length and interpolates to the last color.
    always_comb
    begin
        scaled   = plcm_pkg::ScaleW'({{(plcm_pkg::ScaleW - plcm_pkg::GrayW){1'b0}}, gray_ch.gray}
                   * plcm_pkg::ScaleNum);
        seg_next = '0;
        for (int j = 1; j < plcm_pkg::NumStops - 1; j++)
        begin
            if (scaled >= plcm_pkg::STOP_N[j])
            begin
                seg_next = plcm_pkg::SegW'(j);
            end
        end
        off_next = plcm_pkg::OffW'(scaled - plcm_pkg::STOP_N[seg_next]);
    end

    // ---------------------------------------------------------------- stage 2
    // Weigh the two stop colors: c_lo * (len - off) + c_hi * off.
    always_comb
    begin
        seg_len  = (seg_reg == plcm_pkg::LastSeg) ? plcm_pkg::LenShort : plcm_pkg::LenLong;
        off_rest = seg_len - off_reg;
        seg_hi   = seg_reg + 1'b1;
        for (int c = 0; c < plcm_pkg::NumChan; c++)
        begin
            num2_next[c] =
                  plcm_pkg::NumW'({{(plcm_pkg::NumW - plcm_pkg::ChanW){1'b0}},
                                   plcm_pkg::STOP_BGR[seg_reg][c]}
                                  * {{(plcm_pkg::NumW - plcm_pkg::OffW){1'b0}}, off_rest})
                + plcm_pkg::NumW'({{(plcm_pkg::NumW - plcm_pkg::ChanW){1'b0}},
                                   plcm_pkg::STOP_BGR[seg_hi][c]}
                                  * {{(plcm_pkg::NumW - plcm_pkg::OffW){1'b0}}, off_reg});
        end
    end

    // ---------------------------------------------------------------- stage 3
    // Estimate num / len as (num * floor(2^24 / len)) >> 24; the estimate is
    // the true quotient or one below it.
    always_comb
    begin
        recip = short2_reg ? plcm_pkg::RecipShort : plcm_pkg::RecipLong;
        for (int c = 0; c < plcm_pkg::NumChan; c++)
        begin
            prod3_next[c] = {{plcm_pkg::RecipW{1'b0}}, num2_reg[c]}
                          * {{plcm_pkg::NumW{1'b0}}, recip};
        end
    end

    // ---------------------------------------------------------------- stage 4
    // Check the remainder and bump the estimate when it reaches a full length.
    always_comb
    begin
        logic [plcm_pkg::ChanW-1:0] q_est;
        logic [plcm_pkg::NumW-1:0]  rem;

        q_est   = '0;
        rem     = '0;
        div_len = short3_reg ? plcm_pkg::LenShort : plcm_pkg::LenLong;
        for (int c = 0; c < plcm_pkg::NumChan; c++)
        begin
            q_est = prod3_reg[c][plcm_pkg::RecipShift +: plcm_pkg::ChanW];
            rem   = num3_reg[c]
                  - plcm_pkg::NumW'({{(plcm_pkg::NumW - plcm_pkg::ChanW){1'b0}}, q_est}
                                    * {{(plcm_pkg::NumW - plcm_pkg::OffW){1'b0}}, div_len});
            if (rem >= {{(plcm_pkg::NumW - plcm_pkg::OffW){1'b0}}, div_len})
            begin
                bgr_next[c] = q_est + 1'b1;
            end
            else
            begin
                bgr_next[c] = q_est;
            end
        end
    end

    // ------------------------------------------------------------- valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= gray_ch.valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // -------------------------------------------------------------- payload
    // Load a stage only when a beat is actually present, otherwise hold.
    always_ff @(posedge clk)
    begin
        if (en1 && gray_ch.valid)
        begin
            seg_reg <= seg_next;
            off_reg <= off_next;
        end
        if (en2 && v1_reg)
        begin
            short2_reg <= (seg_reg == plcm_pkg::LastSeg);
            num2_reg   <= num2_next;
        end
        if (en3 && v2_reg)
        begin
            short3_reg <= short2_reg;
            num3_reg   <= num2_reg;
            prod3_reg  <= prod3_next;
        end
        if (en4 && v3_reg)
        begin
            bgr_reg <= bgr_next;
        end
    end

    assign color_ch.valid = v4_reg;
    assign color_ch.blue  = bgr_reg[0];
    assign color_ch.green = bgr_reg[1];
    assign color_ch.red   = bgr_reg[2];

endmodule
